>>> design/bsrc_pkg.sv
// Shared constants, types and state codes for the byte stream residue checksum.
`default_nettype none

package bsrc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ACC_W  = 64;
	localparam int unsigned DIV_W  = 32;
	localparam int unsigned TOP_LO = 56;
	localparam int unsigned CNT_W  = $clog2(ACC_W);

	localparam logic [DIV_W-1:0] DIVISOR_RST = DIV_W'(1);
	localparam logic [ACC_W-1:0] ACC_RST     = ACC_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

`default_nettype wire

>>> design/byte_stream_residue_checksum.sv
// Top level: byte accumulator, sequencer and output register around the serial remainder unit.
//
// The message enters on s_axis one byte per word, most significant byte first, with
// s_axis_tlast on its final byte. The byte string, with a leading one digit, is read
// as a base-256 number; the checksum is that number modulo the divisor and leaves on
// m_axis as one 32-bit word per message. The divisor is written on the cfg channel
// (always ready); the user must write it only while the block is idle, as the block
// itself does not enforce this. Zero selects a modulus of 2^32. A byte that leaves the
// accumulator below 2^56 is shifted straight in. A byte that fills the top accumulator
// byte, and every last byte, starts a 64-step bit-serial remainder, and the input is not
// ready again until it finishes; one in about four bytes does. Once the remainder of a
// last byte finishes, the checksum is loaded into the output register when that is free.
// The output register lets the next message start while a checksum waits; if a second
// checksum is ready before the first is taken, input stalls until m_axis_tready.
// Reset sets the accumulator to one, the divisor to one and drops m_axis_tvalid.
`default_nettype none

module byte_stream_residue_checksum
	import bsrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic              s_axis_tlast,   // last_byte
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [DIV_W-1:0]  m_axis_tdata,   // [31:0] checksum
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [DIV_W-1:0]  cfg_data        // [31:0] divisor
);

	state_t           state_q;
	state_t           state_next;
	logic [ACC_W-1:0] acc_q;
	logic [DIV_W-1:0] divisor_q;
	logic             last_q;
	logic             out_valid_q;
	logic [DIV_W-1:0] out_data_q;

	logic [ACC_W-1:0] acc_next;
	logic             in_fire;
	logic             need_mod;
	logic             out_free;
	logic             load_out;
	mod_req_t         req;
	mod_stat_t        stat;
	logic [DIV_W-1:0] rem;

	assign acc_next = {acc_q[TOP_LO-1:0], s_axis_tdata};
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign need_mod = (acc_next[ACC_W-1:TOP_LO] != '0) || s_axis_tlast;
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && need_mod) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.done) begin
					if (!last_q || out_free) begin
						state_next = ST_IDLE;
					end else begin
						state_next = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_RUN:  load_out      = stat.done && last_q && out_free;
			ST_HOLD: load_out      = out_free;
			default: begin
				s_axis_tready = 1'b0;
				load_out      = 1'b0;
			end
		endcase
	end

	assign req.start    = in_fire && need_mod;
	assign req.dividend = acc_next;
	assign req.divisor  = divisor_q;

	bsrc_serial_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.stat      (stat),
		.remainder (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= ACC_RST;
			divisor_q   <= DIVISOR_RST;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready) begin
				divisor_q <= cfg_data;
			end
			if (in_fire) begin
				last_q <= s_axis_tlast;
				if (!need_mod) begin
					acc_q <= acc_next;
				end
			end
			if (state_q == ST_RUN && stat.done) begin
				acc_q <= last_q ? ACC_RST : {{(ACC_W-DIV_W){1'b0}}, rem};
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= rem;
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> design/bsrc_serial_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle, zero divisor means 2^32.
`default_nettype none

module bsrc_serial_mod
	import bsrc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mod_req_t         req,
	output mod_stat_t             stat,
	output logic      [DIV_W-1:0] remainder
);

	logic [ACC_W-1:0] dvd_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic [DIV_W-1:0] rem_next;

	assign trial    = {rem_q, dvd_q[ACC_W-1]};
	assign diff     = trial - dvs_q;
	assign rem_next = (trial >= dvs_q) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= (req.divisor == '0) ? {1'b1, {DIV_W{1'b0}}} : {1'b0, req.divisor};
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ACC_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> design/bsrc_checker.sv
// Port-level checker for the byte stream residue checksum, bound to the top level.
`default_nettype none

module bsrc_checker
	import bsrc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic              s_axis_tlast,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [DIV_W-1:0]  m_axis_tdata
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("input taken while final remainder runs");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("checksum appeared without a remainder run");

endmodule

bind byte_stream_residue_checksum bsrc_checker u_bsrc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/residue_checksum_checker.sv
// Checker: predicts each message checksum from the observed bytes and compares m_axis words.
`default_nettype none

module residue_checksum_checker
	import bsrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_valid,
	input  wire logic              s_ready,
	input  wire logic [BYTE_W-1:0] s_data,
	input  wire logic              s_last,
	input  wire logic              m_valid,
	input  wire logic              m_ready,
	input  wire logic [DIV_W-1:0]  m_data,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [DIV_W-1:0]  cfg_data,
	output int                     pending,
	output int                     errors
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [ACC_W-1:0] running_value;
	logic [DIV_W-1:0] modulus;
	logic [DIV_W-1:0] expected_sums[$];
	int               mismatches;

	function automatic logic [ACC_W-1:0] residue_of(input logic [ACC_W-1:0] v,
		input logic [DIV_W-1:0] m);
		if (m == '0)
			return {{(ACC_W-DIV_W){1'b0}}, v[DIV_W-1:0]};
		return v % {{(ACC_W-DIV_W){1'b0}}, m};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [DIV_W-1:0] want;
		if (!arst_n) begin
			running_value = ACC_RST;
			modulus       = DIVISOR_RST;
			expected_sums.delete();
			mismatches    = 0;
			pending      <= 0;
			errors       <= 0;
		end else begin
			if (m_valid && m_ready) begin
				if (expected_sums.size() == 0) begin
					if (mismatches < 10)
						$display("%0t unexpected checksum word %h", $realtime, m_data);
					mismatches++;
				end else begin
					want = expected_sums.pop_front();
					if (m_data !== want) begin
						if (mismatches < 10)
							$display("%0t checksum mismatch: expected %h, got %h",
								$realtime, want, m_data);
						mismatches++;
					end
				end
			end
			if (s_valid && s_ready) begin
				running_value = {running_value[ACC_W-BYTE_W-1:0], s_data};
				if (running_value[ACC_W-1:TOP_LO] != '0)
					running_value = residue_of(running_value, modulus);
				if (s_last) begin
					want = DIV_W'(residue_of(running_value, modulus));
					expected_sums.push_back(want);
					running_value = ACC_RST;
				end
			end
			if (cfg_valid && cfg_ready)
				modulus = cfg_data;
			pending <= expected_sums.size();
			errors  <= mismatches;
		end
	end

endmodule

`default_nettype wire

>>> tb/byte_stream_residue_checksum_tb.sv
// Testbench top: clock, reset, byte stream and divisor stimulus, receiver backpressure, verdict.
`default_nettype none

module byte_stream_residue_checksum_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsrc_pkg::*;

	localparam int IDLE_PCT    = 34;
	localparam int HOLD_CYCLES = 1500;
	localparam int WATCHDOG    = 6000;
	localparam int DRAIN       = 100;
	localparam int PHASES      = 12;
	localparam int PHASE_BYTES = 128;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata  = '0;
	logic              s_axis_tlast  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DIV_W-1:0]  m_axis_tdata;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [DIV_W-1:0]  cfg_data      = '0;

	int pending;
	int errors;
	int sums_taken = 0;
	int quiet_cycles = 0;
	bit gaps_off = 1'b0;
	bit held = 1'b0;

	always #2 clk = ~clk;

	byte_stream_residue_checksum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	residue_checksum_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.s_data    (s_axis_tdata),
		.s_last    (s_axis_tlast),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors)
	);

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sums_taken <= sums_taken + 1;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (!held && sums_taken >= 30) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= gaps_off || ($urandom_range(99) >= IDLE_PCT);
				@(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last);
		if (!gaps_off)
			while ($urandom_range(99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_divisor(input logic [DIV_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DIV_W-1:0] pick_divisor(input int p);
		case (p)
			0: return '0;
			1: return '1;
			2: return DIV_W'(1);
			3: return DIV_W'(2);
			4: return {1'b1, {(DIV_W-1){1'b0}}};
			default: begin
				if ($urandom_range(1) == 0)
					return DIV_W'($urandom_range(1000, 1));
				return DIV_W'($urandom());
			end
		endcase
	endfunction

	task automatic send_messages(input int n_bytes);
		int sent;
		int len;
		int r;
		logic [BYTE_W-1:0] b;
		sent = 0;
		while (sent < n_bytes) begin
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(8, 1);
			else if (r < 95)
				len = $urandom_range(24, 9);
			else
				len = $urandom_range(80, 25);
			for (int k = 0; k < len && sent < n_bytes; k++) begin
				r = $urandom_range(9);
				if (r == 0)
					b = '0;
				else if (r == 1)
					b = '1;
				else
					b = BYTE_W'($urandom_range(255));
				send_byte(b, k == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00, 1'b1);
		settle();
		write_divisor('0);
		repeat (8) send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();
		write_divisor('1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b1);
		settle();
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		settle();
		write_divisor(DIV_W'(7));
		send_byte(8'h04, 1'b1);
		settle();
		write_divisor(DIV_W'(2));
		send_byte(8'hFF, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_divisor(pick_divisor(p));
			gaps_off = (p == 6);
			send_messages(PHASE_BYTES);
		end
		gaps_off = 1'b0;
		settle();

		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
